// File: rtl/core/pmg_pkg.sv
`timescale 1ns / 1ps

package pmg_pkg;

  localparam int CW       = 32;                // coordinate and result width
  localparam int FB       = 16;                // fraction bits
  localparam int DW       = CW + 1;            // offset width
  localparam int SQW      = 2 * DW;            // squared distance width
  localparam int SQ_STEPS = SQW / 2;           // square root digit steps
  localparam int SQ_RW    = DW + 3;            // square root remainder width
  localparam int MW       = 31;                // mass and radius width
  localparam int NUMW     = MW + 2 * FB;       // mass numerator and g width
  localparam int PLW      = CW + DW;           // low partial product width
  localparam int PHW      = NUMW - CW + DW;    // high partial product width
  localparam int PW       = NUMW + DW;         // full product width
  localparam int NHW      = PW - CW;           // product bits above the quotient
  localparam int CFG_AW   = 2;

  localparam logic [CFG_AW-1:0] CFG_BODY_X      = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BODY_Y      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BODY_MASS   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_BODY_RADIUS = 2'd3;

  localparam logic [MW-1:0] MASS_RESET = MW'(1) << FB;

  localparam logic [1:0] OUT_DEPTH = 2'd2;

  typedef struct packed {
    logic          in_body;
    logic          sx;
    logic          sy;
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
  } side_t;

  typedef struct packed {
    logic          in_body;
    logic [CW-1:0] accel_y;
    logic [CW-1:0] accel_x;
  } res_t;

endpackage

// File: rtl/core/pmg_front.sv
`timescale 1ns / 1ps

module pmg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pmg_pkg::CW-1:0]        probe_x,
  input  logic [pmg_pkg::CW-1:0]        probe_y,
  input  logic [pmg_pkg::CW-1:0]        body_x,
  input  logic [pmg_pkg::CW-1:0]        body_y,
  input  logic [pmg_pkg::MW-1:0]        body_radius,
  output logic                          out_valid,
  output logic [pmg_pkg::SQW-1:0]       r2,
  output pmg_pkg::side_t                side_o
);

  logic [3:0]                    vld_r;
  logic [pmg_pkg::DW-1:0]        dx_r, dy_r;
  pmg_pkg::side_t                s2_r, s3_r, s4_r;
  logic [pmg_pkg::SQW-1:0]       sqx_r, sqy_r, r2_r;
  logic [2*pmg_pkg::MW-1:0]      rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {body_x[pmg_pkg::CW-1], body_x} - {probe_x[pmg_pkg::CW-1], probe_x};
      dy_r <= {body_y[pmg_pkg::CW-1], body_y} - {probe_y[pmg_pkg::CW-1], probe_y};

      s2_r.in_body <= 1'b0;
      s2_r.sx      <= dx_r[pmg_pkg::DW-1];
      s2_r.sy      <= dy_r[pmg_pkg::DW-1];
      s2_r.ax      <= dx_r[pmg_pkg::DW-1] ? (~dx_r + pmg_pkg::DW'(1)) : dx_r;
      s2_r.ay      <= dy_r[pmg_pkg::DW-1] ? (~dy_r + pmg_pkg::DW'(1)) : dy_r;

      sqx_r  <= s2_r.ax * s2_r.ax;
      sqy_r  <= s2_r.ay * s2_r.ay;
      rad2_r <= body_radius * body_radius;
      s3_r   <= s2_r;

      r2_r    <= sqx_r + sqy_r;
      s4_r.sx <= s3_r.sx;
      s4_r.sy <= s3_r.sy;
      s4_r.ax <= s3_r.ax;
      s4_r.ay <= s3_r.ay;
      // exact test against the squared radius
      s4_r.in_body <= (sqx_r + sqy_r) < pmg_pkg::SQW'(rad2_r);
    end
  end

  assign out_valid = vld_r[3];
  assign r2        = r2_r;
  assign side_o    = s4_r;

endmodule

// File: rtl/core/pmg_sqrt.sv
`timescale 1ns / 1ps

module pmg_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [pmg_pkg::SQW-1:0] r2,
  input  pmg_pkg::side_t          side_i,
  output logic                    out_valid,
  output logic [pmg_pkg::DW-1:0]  root,
  output pmg_pkg::side_t          side_o
);

  logic [pmg_pkg::SQ_STEPS-1:0] vld_r;
  logic [pmg_pkg::SQW-1:0]      n_r    [pmg_pkg::SQ_STEPS];
  logic [pmg_pkg::SQ_RW-1:0]    rem_r  [pmg_pkg::SQ_STEPS];
  logic [pmg_pkg::DW-1:0]       root_r [pmg_pkg::SQ_STEPS];
  pmg_pkg::side_t               side_r [pmg_pkg::SQ_STEPS];

  for (genvar k = 0; k < pmg_pkg::SQ_STEPS; k++) begin : g_step
    logic                      v_in;
    logic [pmg_pkg::SQW-1:0]   n_in;
    logic [pmg_pkg::SQ_RW-1:0] rem_in, rem_sh, trial;
    logic [pmg_pkg::DW-1:0]    root_in;
    pmg_pkg::side_t            s_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign n_in    = r2;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign s_in    = side_r[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign rem_sh = {rem_in[pmg_pkg::SQ_RW-3:0], n_in[pmg_pkg::SQW-1-2*k -: 2]};
    assign trial  = pmg_pkg::SQ_RW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_in;
        side_r[k] <= s_in;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[pmg_pkg::DW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[pmg_pkg::DW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[pmg_pkg::SQ_STEPS-1];
  assign root      = root_r[pmg_pkg::SQ_STEPS-1];
  assign side_o    = side_r[pmg_pkg::SQ_STEPS-1];

endmodule

// File: rtl/core/pmg_gdiv.sv
`timescale 1ns / 1ps

module pmg_gdiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [pmg_pkg::DW-1:0]   root_i,
  input  pmg_pkg::side_t           side_i,
  input  logic [pmg_pkg::MW-1:0]   body_mass,
  output logic                     out_valid,
  output logic [pmg_pkg::NUMW-1:0] g,
  output logic [pmg_pkg::DW-1:0]   root_o,
  output pmg_pkg::side_t           side_o
);

  logic                     v0_r;
  logic [pmg_pkg::SQW-1:0]  rsq0_r;
  logic [pmg_pkg::DW-1:0]   root0_r;
  pmg_pkg::side_t           side0_r;

  logic [pmg_pkg::NUMW-1:0] vld_r;
  logic [pmg_pkg::SQW-1:0]  rsq_r  [pmg_pkg::NUMW];
  logic [pmg_pkg::SQW-1:0]  rem_r  [pmg_pkg::NUMW];
  logic [pmg_pkg::NUMW-1:0] q_r    [pmg_pkg::NUMW];
  logic [pmg_pkg::DW-1:0]   root_r [pmg_pkg::NUMW];
  pmg_pkg::side_t           side_r [pmg_pkg::NUMW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsq0_r  <= root_i * root_i;
      root0_r <= root_i;
      side0_r <= side_i;
    end
  end

  // restoring divide of mass * 2^(2*FB) by r^2, one quotient bit per stage
  for (genvar j = 0; j < pmg_pkg::NUMW; j++) begin : g_step
    logic                     v_in, nbit;
    logic [pmg_pkg::SQW-1:0]  rsq_in, rem_in;
    logic [pmg_pkg::NUMW-1:0] q_in;
    logic [pmg_pkg::DW-1:0]   root_in;
    logic [pmg_pkg::SQW:0]    sh;
    pmg_pkg::side_t           s_in;

    if (j == 0) begin : g_first
      assign v_in    = v0_r;
      assign rsq_in  = rsq0_r;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign root_in = root0_r;
      assign s_in    = side0_r;
    end else begin : g_next
      assign v_in    = vld_r[j-1];
      assign rsq_in  = rsq_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign root_in = root_r[j-1];
      assign s_in    = side_r[j-1];
    end

    if (pmg_pkg::NUMW - 1 - j >= 2 * pmg_pkg::FB) begin : g_mass_bit
      assign nbit = body_mass[pmg_pkg::NUMW - 1 - j - 2 * pmg_pkg::FB];
    end else begin : g_zero_bit
      assign nbit = 1'b0;
    end

    assign sh = {rem_in, nbit};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rsq_r[j]  <= rsq_in;
        root_r[j] <= root_in;
        side_r[j] <= s_in;
        if (sh >= {1'b0, rsq_in}) begin
          rem_r[j] <= pmg_pkg::SQW'(sh - {1'b0, rsq_in});
          q_r[j]   <= {q_in[pmg_pkg::NUMW-2:0], 1'b1};
        end else begin
          rem_r[j] <= sh[pmg_pkg::SQW-1:0];
          q_r[j]   <= {q_in[pmg_pkg::NUMW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[pmg_pkg::NUMW-1];
  assign g         = q_r[pmg_pkg::NUMW-1];
  assign root_o    = root_r[pmg_pkg::NUMW-1];
  assign side_o    = side_r[pmg_pkg::NUMW-1];

endmodule

// File: rtl/core/pmg_scale.sv
`timescale 1ns / 1ps

module pmg_scale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [pmg_pkg::NUMW-1:0] g,
  input  logic [pmg_pkg::DW-1:0]   root_i,
  input  pmg_pkg::side_t           side_i,
  output logic                     out_valid,
  output pmg_pkg::res_t            res
);

  function automatic logic [pmg_pkg::CW-1:0] fin_val(
    input logic [pmg_pkg::CW-1:0] q,
    input logic                   ovf,
    input logic                   neg,
    input logic                   kill
  );
    logic                   big;
    logic [pmg_pkg::CW-1:0] m;
    big = ovf | (neg ? (q[pmg_pkg::CW-1] & (|q[pmg_pkg::CW-2:0])) : q[pmg_pkg::CW-1]);
    if (kill) begin
      m = '0;
    end else if (neg) begin
      m = big ? {1'b1, {(pmg_pkg::CW-1){1'b0}}} : q;
      m = ~m + pmg_pkg::CW'(1);
    end else begin
      m = big ? {1'b0, {(pmg_pkg::CW-1){1'b1}}} : q;
    end
    return m;
  endfunction

  // stage A: partial products, stage B: sum, stage C: quotient overflow test
  logic [2:0]               vabc_r;
  logic [pmg_pkg::PLW-1:0]  pxl_r, pyl_r;
  logic [pmg_pkg::PHW-1:0]  pxh_r, pyh_r;
  logic [pmg_pkg::PW-1:0]   nxb_r, nyb_r, nxc_r, nyc_r;
  logic                     ovxc_r, ovyc_r;
  logic [pmg_pkg::DW-1:0]   rta_r, rtb_r, rtc_r;
  pmg_pkg::side_t           sa_r, sb_r, sc_r;

  logic [pmg_pkg::CW-1:0]   vld_r;
  logic [pmg_pkg::PW-1:0]   nx_r  [pmg_pkg::CW];
  logic [pmg_pkg::PW-1:0]   ny_r  [pmg_pkg::CW];
  logic [pmg_pkg::DW-1:0]   remx_r[pmg_pkg::CW];
  logic [pmg_pkg::DW-1:0]   remy_r[pmg_pkg::CW];
  logic [pmg_pkg::CW-1:0]   qx_r  [pmg_pkg::CW];
  logic [pmg_pkg::CW-1:0]   qy_r  [pmg_pkg::CW];
  logic                     ovx_r [pmg_pkg::CW];
  logic                     ovy_r [pmg_pkg::CW];
  logic [pmg_pkg::DW-1:0]   rt_r  [pmg_pkg::CW];
  pmg_pkg::side_t           s_r   [pmg_pkg::CW];

  logic                     vf_r;
  pmg_pkg::res_t            res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vabc_r <= '0;
      vf_r   <= 1'b0;
    end else if (en) begin
      vabc_r <= {vabc_r[1:0], in_valid};
      vf_r   <= vld_r[pmg_pkg::CW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r <= g[pmg_pkg::CW-1:0] * side_i.ax;
      pxh_r <= g[pmg_pkg::NUMW-1:pmg_pkg::CW] * side_i.ax;
      pyl_r <= g[pmg_pkg::CW-1:0] * side_i.ay;
      pyh_r <= g[pmg_pkg::NUMW-1:pmg_pkg::CW] * side_i.ay;
      rta_r <= root_i;
      sa_r  <= side_i;

      nxb_r <= pmg_pkg::PW'(pxl_r) + (pmg_pkg::PW'(pxh_r) << pmg_pkg::CW);
      nyb_r <= pmg_pkg::PW'(pyl_r) + (pmg_pkg::PW'(pyh_r) << pmg_pkg::CW);
      rtb_r <= rta_r;
      sb_r  <= sa_r;

      // quotient reaches 2^CW or more: saturate
      nxc_r  <= nxb_r;
      nyc_r  <= nyb_r;
      ovxc_r <= nxb_r[pmg_pkg::PW-1:pmg_pkg::CW] >= pmg_pkg::NHW'(rtb_r);
      ovyc_r <= nyb_r[pmg_pkg::PW-1:pmg_pkg::CW] >= pmg_pkg::NHW'(rtb_r);
      rtc_r  <= rtb_r;
      sc_r   <= sb_r;
    end
  end

  for (genvar k = 0; k < pmg_pkg::CW; k++) begin : g_step
    logic                   v_in, ovx_in, ovy_in;
    logic [pmg_pkg::PW-1:0] nx_in, ny_in;
    logic [pmg_pkg::DW-1:0] remx_in, remy_in, rt_in;
    logic [pmg_pkg::CW-1:0] qx_in, qy_in;
    logic [pmg_pkg::DW:0]   shx, shy;
    pmg_pkg::side_t         s_in;

    if (k == 0) begin : g_first
      assign v_in    = vabc_r[2];
      assign nx_in   = nxc_r;
      assign ny_in   = nyc_r;
      assign remx_in = nxc_r[pmg_pkg::CW+pmg_pkg::DW-1:pmg_pkg::CW];
      assign remy_in = nyc_r[pmg_pkg::CW+pmg_pkg::DW-1:pmg_pkg::CW];
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign ovx_in  = ovxc_r;
      assign ovy_in  = ovyc_r;
      assign rt_in   = rtc_r;
      assign s_in    = sc_r;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign nx_in   = nx_r[k-1];
      assign ny_in   = ny_r[k-1];
      assign remx_in = remx_r[k-1];
      assign remy_in = remy_r[k-1];
      assign qx_in   = qx_r[k-1];
      assign qy_in   = qy_r[k-1];
      assign ovx_in  = ovx_r[k-1];
      assign ovy_in  = ovy_r[k-1];
      assign rt_in   = rt_r[k-1];
      assign s_in    = s_r[k-1];
    end

    assign shx = {remx_in, nx_in[pmg_pkg::CW-1-k]};
    assign shy = {remy_in, ny_in[pmg_pkg::CW-1-k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[k]  <= nx_in;
        ny_r[k]  <= ny_in;
        ovx_r[k] <= ovx_in;
        ovy_r[k] <= ovy_in;
        rt_r[k]  <= rt_in;
        s_r[k]   <= s_in;
        if (shx >= {1'b0, rt_in}) begin
          remx_r[k] <= pmg_pkg::DW'(shx - {1'b0, rt_in});
          qx_r[k]   <= {qx_in[pmg_pkg::CW-2:0], 1'b1};
        end else begin
          remx_r[k] <= shx[pmg_pkg::DW-1:0];
          qx_r[k]   <= {qx_in[pmg_pkg::CW-2:0], 1'b0};
        end
        if (shy >= {1'b0, rt_in}) begin
          remy_r[k] <= pmg_pkg::DW'(shy - {1'b0, rt_in});
          qy_r[k]   <= {qy_in[pmg_pkg::CW-2:0], 1'b1};
        end else begin
          remy_r[k] <= shy[pmg_pkg::DW-1:0];
          qy_r[k]   <= {qy_in[pmg_pkg::CW-2:0], 1'b0};
        end
      end
    end
  end

  logic           kill;
  pmg_pkg::side_t s_last;

  assign s_last = s_r[pmg_pkg::CW-1];
  // zero inside the body and at zero distance
  assign kill   = s_last.in_body | (rt_r[pmg_pkg::CW-1] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.in_body <= s_last.in_body;
      res_r.accel_x <= fin_val(qx_r[pmg_pkg::CW-1], ovx_r[pmg_pkg::CW-1], s_last.sx, kill);
      res_r.accel_y <= fin_val(qy_r[pmg_pkg::CW-1], ovy_r[pmg_pkg::CW-1], s_last.sy, kill);
    end
  end

  assign out_valid = vf_r;
  assign res       = res_r;

endmodule

// File: rtl/core/point_mass_gravity_accel.sv
`timescale 1ns / 1ps

// Gravity acceleration toward one configured point mass, signed Q16.16 in and out.
// A fully pipelined kernel: one probe request is taken every clock while in_tready is
// high, and its result leaves the output register after 4 offset/square stages, 33
// square root stages, 64 stages for mass/r^2, 36 for the scaling multiply, divide by r
// and saturation, and one in the output buffer. The stall from out_tready freezes the
// whole pipeline behind a two-entry output buffer, so in_tready depends only on
// registers. Write the body registers only while no request is in flight.
module point_mass_gravity_accel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pmg_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [pmg_pkg::CW-1:0]        cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*pmg_pkg::CW-1:0]      in_tdata,   // probe_x, probe_y
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*pmg_pkg::CW-1:0]      out_tdata,  // accel_x, accel_y
  output logic                          out_tuser   // inside_body
);

  logic [pmg_pkg::CW-1:0]   body_x_r, body_y_r;
  logic [pmg_pkg::MW-1:0]   body_mass_r, body_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_x_r      <= '0;
      body_y_r      <= '0;
      body_mass_r   <= pmg_pkg::MASS_RESET;
      body_radius_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pmg_pkg::CFG_BODY_X:      body_x_r      <= cfg_wdata;
        pmg_pkg::CFG_BODY_Y:      body_y_r      <= cfg_wdata;
        pmg_pkg::CFG_BODY_MASS:   body_mass_r   <= cfg_wdata[pmg_pkg::MW-1:0];
        pmg_pkg::CFG_BODY_RADIUS: body_radius_r <= cfg_wdata[pmg_pkg::MW-1:0];
        default: ;
      endcase
    end
  end

  logic                     en;
  logic                     fr_valid, sq_valid, gd_valid, fin_valid;
  logic [pmg_pkg::SQW-1:0]  r2;
  logic [pmg_pkg::DW-1:0]   root, gd_root;
  logic [pmg_pkg::NUMW-1:0] g;
  pmg_pkg::side_t           fr_side, sq_side, gd_side;
  pmg_pkg::res_t            fin;

  logic [1:0]               cnt_r, cnt_nxt;
  pmg_pkg::res_t            slot0_r, slot1_r;
  logic                     push, pop;

  assign en        = (cnt_r != pmg_pkg::OUT_DEPTH);
  assign in_tready = en;

  pmg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .probe_x     (in_tdata[pmg_pkg::CW-1:0]),
    .probe_y     (in_tdata[2*pmg_pkg::CW-1:pmg_pkg::CW]),
    .body_x      (body_x_r),
    .body_y      (body_y_r),
    .body_radius (body_radius_r),
    .out_valid   (fr_valid),
    .r2          (r2),
    .side_o      (fr_side)
  );

  pmg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .r2        (r2),
    .side_i    (fr_side),
    .out_valid (sq_valid),
    .root      (root),
    .side_o    (sq_side)
  );

  pmg_gdiv u_gdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .root_i    (root),
    .side_i    (sq_side),
    .body_mass (body_mass_r),
    .out_valid (gd_valid),
    .g         (g),
    .root_o    (gd_root),
    .side_o    (gd_side)
  );

  pmg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (gd_valid),
    .g         (g),
    .root_i    (gd_root),
    .side_i    (gd_side),
    .out_valid (fin_valid),
    .res       (fin)
  );

  // two-entry output buffer; slot0 is the head
  assign push    = en & fin_valid;
  assign pop     = out_tvalid & out_tready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt_r == 2'd0 && push) || (cnt_r == 2'd1 && push && pop)) begin
      slot0_r <= fin;
    end else if (cnt_r == pmg_pkg::OUT_DEPTH && pop) begin
      slot0_r <= slot1_r;
    end
    if (cnt_r == 2'd1 && push && !pop) begin
      slot1_r <= fin;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {slot0_r.accel_y, slot0_r.accel_x};
  assign out_tuser  = slot0_r.in_body;

endmodule
